// ===== rtl/rcd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package rcd_pkg;
  localparam int MaxPointsDef = 128;
  localparam int CoordW = 32;
  localparam int RadiusW = 31;
  localparam logic [RadiusW-1:0] RadiusRst = 31'd65536;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_SEED_RD,
    ST_SEED_WAIT,
    ST_SEED_TAKE,
    ST_CAND_RD,
    ST_CAND_WAIT,
    ST_CAND_TEST,
    ST_CAND_SQ,
    ST_CAND_SUM,
    ST_DIV,
    ST_EMIT,
    ST_CLEAR
  } state_t;
endpackage
`default_nettype wire

// ===== rtl/radius_cluster_downsample.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Load: one point per cycle, one store write per point until full; in_tready drops after last point.
// Scan per seed: store read, wait, take; per later candidate, when unclaimed: read, wait, |d|,
// axis check with squares, sum compare; when already claimed: read, wait, claim test.
// Each cluster adds a restoring divide; its result is held until the next cluster
// or the scan end, so emits wait on out_tready. A clear step ends each cloud.
// Reset (rst_n low, synchronous) clears control, count and overflow; radius returns to 1.0.
module radius_cluster_downsample
  import rcd_pkg::*;
#(
  parameter int MAX_POINTS = MaxPointsDef
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_we,
  input  wire logic [31:0]  cfg_wdata,    // [30:0] radius
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [95:0]  in_tdata,     // px, py, pz
  input  wire logic         in_tlast,     // last_point
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [103:0]      out_tdata,    // cx, cy, cz, members
  output logic              out_tlast,    // last_result
  output logic [1:0]        out_tuser     // empty_res, overflow
);
  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int SW = CoordW + CW;

  state_t state_r, state_nxt;
  logic [RadiusW-1:0] radius_r;
  // entry: [96] claimed flag (written as 0 on load), [95:0] pz, py, px
  logic [96:0] mem [MAX_POINTS];
  logic [96:0] rd_q;
  logic [AW-1:0] rd_addr;
  logic wr_en;
  logic [AW-1:0] wr_addr;
  logic [96:0] wr_data;
  logic [CW-1:0] count_r, seed_r, cand_r, members_r;
  logic ovf_r, found_r;
  logic [CoordW-1:0] sx_r, sy_r, sz_r;
  logic signed [SW-1:0] acc_r [3];
  logic [32:0] d_r [3];
  logic [63:0] sq [3];
  logic [65:0] q_r [3];
  logic [67:0] sumsq;
  logic [61:0] rsq;
  logic far_r;
  logic join_ok;
  // divider
  logic [SW-1:0] num_r [3];
  logic [SW-1:0] rem_r [3];
  logic [2:0] neg_r;
  logic [$clog2(SW+1)-1:0] dcnt_r;
  logic [CoordW-1:0] quo [3];
  // held result
  logic [CoordW-1:0] res_r [3];
  logic [7:0] omem_r;
  logic last_r, empty_r;

  always_ff @(posedge clk) begin
    if (!rst_n) radius_r <= RadiusRst;
    else if (cfg_we) radius_r <= cfg_wdata[RadiusW-1:0];
  end

  wire load_acc = in_tvalid && in_tready;
  wire out_acc = out_tvalid && out_tready;
  wire cand_end = (cand_r >= count_r);

  always_comb begin
    unique case (state_r)
      ST_SEED_RD, ST_SEED_WAIT, ST_SEED_TAKE: rd_addr = seed_r[AW-1:0];
      default: rd_addr = cand_r[AW-1:0];
    endcase
  end

  // single write port: load, seed claim, candidate claim
  always_comb begin
    wr_en = 1'b0;
    wr_addr = cand_r[AW-1:0];
    wr_data = {1'b1, rd_q[95:0]};
    unique case (state_r)
      ST_LOAD: begin
        wr_en = load_acc && (count_r < CW'(MAX_POINTS));
        wr_addr = count_r[AW-1:0];
        wr_data = {1'b0, in_tdata};
      end
      ST_SEED_TAKE: begin
        wr_en = !rd_q[96];
        wr_addr = seed_r[AW-1:0];
      end
      ST_CAND_SUM: wr_en = join_ok;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_q <= mem[rd_addr];
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sq[k] = d_r[k][31:0] * d_r[k][31:0];
      quo[k] = neg_r[k] ? CoordW'(-num_r[k]) : CoordW'(num_r[k]);
    end
    rsq = radius_r * radius_r;
    sumsq = {2'b0, q_r[0]} + {2'b0, q_r[1]} + {2'b0, q_r[2]};
    join_ok = !far_r && (sumsq < {6'd0, rsq});
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD:      if (load_acc && in_tlast) state_nxt = ST_SEED_RD;
      ST_SEED_RD:   state_nxt = (seed_r >= count_r) ? ST_EMIT : ST_SEED_WAIT;
      ST_SEED_WAIT: state_nxt = ST_SEED_TAKE;
      ST_SEED_TAKE: state_nxt = rd_q[96] ? ST_SEED_RD : ST_CAND_RD;
      ST_CAND_RD: begin
        if (cand_end) state_nxt = (members_r >= CW'(2)) ? ST_DIV : ST_SEED_RD;
        else state_nxt = ST_CAND_WAIT;
      end
      ST_CAND_WAIT: state_nxt = ST_CAND_TEST;
      ST_CAND_TEST: state_nxt = rd_q[96] ? ST_CAND_RD : ST_CAND_SQ;
      ST_CAND_SQ:   state_nxt = ST_CAND_SUM;
      ST_CAND_SUM:  state_nxt = ST_CAND_RD;
      // a held result goes out first; otherwise the new one is held and the scan resumes
      ST_DIV:       if (dcnt_r == '0) state_nxt = found_r ? ST_EMIT : ST_SEED_RD;
      ST_EMIT: if (out_acc) state_nxt = last_r ? ST_CLEAR : ST_SEED_RD;
      ST_CLEAR:     state_nxt = ST_LOAD;
      default:      state_nxt = ST_LOAD;
    endcase
  end

  // outputs
  always_comb begin
    in_tready = (state_r == ST_LOAD);
    out_tvalid = (state_r == ST_EMIT);
    out_tdata = {omem_r, res_r[2], res_r[1], res_r[0]};
    out_tlast = last_r;
    out_tuser = {ovf_r, empty_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      count_r <= '0;
      ovf_r <= 1'b0;
      found_r <= 1'b0;
      seed_r <= '0;
      last_r <= 1'b0;
      empty_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        ST_LOAD: if (load_acc) begin
          if (count_r < CW'(MAX_POINTS)) count_r <= count_r + 1'b1;
          else ovf_r <= 1'b1;
          if (in_tlast) begin
            seed_r <= '0;
            found_r <= 1'b0;
          end
        end
        ST_SEED_RD: begin
          // scan done: the held cluster becomes the last result, else the empty result
          if (seed_r >= count_r) begin
            last_r <= 1'b1;
            if (!found_r) begin
              empty_r <= 1'b1;
              omem_r <= '0;
              res_r[0] <= '0; res_r[1] <= '0; res_r[2] <= '0;
            end
          end
        end
        ST_SEED_TAKE: begin
          if (rd_q[96]) seed_r <= seed_r + 1'b1;
          else begin
            {sz_r, sy_r, sx_r} <= rd_q[95:0];
            acc_r[0] <= SW'($signed(rd_q[31:0]));
            acc_r[1] <= SW'($signed(rd_q[63:32]));
            acc_r[2] <= SW'($signed(rd_q[95:64]));
            members_r <= CW'(1);
            cand_r <= seed_r + 1'b1;
          end
        end
        ST_CAND_RD: begin
          if (cand_end) begin
            if (members_r >= CW'(2)) begin
              for (int k = 0; k < 3; k++) begin
                neg_r[k] <= acc_r[k][SW-1];
                num_r[k] <= acc_r[k][SW-1] ? SW'(-acc_r[k]) : SW'(acc_r[k]);
                rem_r[k] <= '0;
              end
              dcnt_r <= ($clog2(SW+1))'(SW);
            end else seed_r <= seed_r + 1'b1;
          end
        end
        ST_CAND_WAIT: ;
        ST_CAND_TEST: begin
          if (rd_q[96]) cand_r <= cand_r + 1'b1;
          d_r[0] <= ($signed({sx_r[31], sx_r}) > $signed({rd_q[31], rd_q[31:0]}))
            ? {sx_r[31], sx_r} - {rd_q[31], rd_q[31:0]}
            : {rd_q[31], rd_q[31:0]} - {sx_r[31], sx_r};
          d_r[1] <= ($signed({sy_r[31], sy_r}) > $signed({rd_q[63], rd_q[63:32]}))
            ? {sy_r[31], sy_r} - {rd_q[63], rd_q[63:32]}
            : {rd_q[63], rd_q[63:32]} - {sy_r[31], sy_r};
          d_r[2] <= ($signed({sz_r[31], sz_r}) > $signed({rd_q[95], rd_q[95:64]}))
            ? {sz_r[31], sz_r} - {rd_q[95], rd_q[95:64]}
            : {rd_q[95], rd_q[95:64]} - {sz_r[31], sz_r};
        end
        ST_CAND_SQ: begin
          far_r <= (d_r[0] >= 33'(radius_r)) || (d_r[1] >= 33'(radius_r))
                   || (d_r[2] >= 33'(radius_r));
          for (int k = 0; k < 3; k++) q_r[k] <= {2'b0, sq[k]};
        end
        ST_CAND_SUM: begin
          if (join_ok) begin
            members_r <= members_r + 1'b1;
            acc_r[0] <= acc_r[0] + SW'($signed(rd_q[31:0]));
            acc_r[1] <= acc_r[1] + SW'($signed(rd_q[63:32]));
            acc_r[2] <= acc_r[2] + SW'($signed(rd_q[95:64]));
          end
          cand_r <= cand_r + 1'b1;
        end
        ST_DIV: begin
          if (dcnt_r == '0) begin
            if (!found_r) begin
              for (int k = 0; k < 3; k++) res_r[k] <= quo[k];
              omem_r <= 8'(members_r);
              found_r <= 1'b1;
              seed_r <= seed_r + 1'b1;
            end
          end else begin
            for (int k = 0; k < 3; k++) begin
              if ({rem_r[k][SW-2:0], num_r[k][SW-1]} >= SW'(members_r)) begin
                rem_r[k] <= {rem_r[k][SW-2:0], num_r[k][SW-1]} - SW'(members_r);
                num_r[k] <= {num_r[k][SW-2:0], 1'b1};
              end else begin
                rem_r[k] <= {rem_r[k][SW-2:0], num_r[k][SW-1]};
                num_r[k] <= {num_r[k][SW-2:0], 1'b0};
              end
            end
            dcnt_r <= dcnt_r - 1'b1;
          end
        end
        // held result accepted: the freshly divided cluster takes its place
        ST_EMIT: if (out_acc && !last_r) begin
          for (int k = 0; k < 3; k++) res_r[k] <= quo[k];
          omem_r <= 8'(members_r);
          seed_r <= seed_r + 1'b1;
        end
        ST_CLEAR: begin
          count_r <= '0;
          ovf_r <= 1'b0;
          found_r <= 1'b0;
          last_r <= 1'b0;
          empty_r <= 1'b0;
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import rcd_pkg::*;

  localparam int StoreDepth = MaxPointsDef;
  localparam int IdleWait   = 2 * StoreDepth + 100;  // settle margin after the last result
  localparam int WdogLimit  = 400000;
  localparam int HoldCycles = 600;

  typedef struct {
    logic signed [31:0] x, y, z;
  } point_t;

  typedef struct {
    logic signed [31:0] cx, cy, cz;
    logic [7:0]         members;
    logic               last_res, empty_res, ovf;
  } centroid_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic in_tvalid = 1'b0;
  logic [95:0] in_tdata = '0;       // px, py, pz
  logic in_tlast = 1'b0;            // last_point
  logic in_tready;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [103:0] out_tdata;          // cx, cy, cz, members
  logic out_tlast;                  // last_result
  logic [1:0] out_tuser;            // empty_res, overflow

  // predictor state: current cloud, overflow flag, radius copy
  point_t    cloud_pts[$];
  logic      cloud_ovf = 1'b0;
  logic [30:0] radius_q = RadiusRst;
  centroid_t centroid_q[$];

  int  mismatches = 0;
  int  items_sent = 0;
  bit  rx_hold = 1'b0;
  int  rx_stall = 0;
  int  idle_cycles = 0;

  radius_cluster_downsample i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Strict distance test, squared, no root. Any axis at or past radius fails early,
  // which also keeps the squares inside 64 bits.
  function automatic bit near_seed(point_t a, point_t b);
    longint d[3];
    logic [65:0] acc;
    logic [65:0] r;
    r = radius_q;
    acc = '0;
    d[0] = longint'(a.x) - longint'(b.x);
    d[1] = longint'(a.y) - longint'(b.y);
    d[2] = longint'(a.z) - longint'(b.z);
    for (int k = 0; k < 3; k++) begin
      if (d[k] < 0) d[k] = -d[k];
      if (d[k] >= longint'(radius_q)) return 1'b0;
      acc += 66'(d[k]) * 66'(d[k]);
    end
    return acc < r * r;
  endfunction

  // Greedy scan in load order; fills centroid_q for the finished cloud.
  task automatic cluster_cloud();
    bit taken[];
    int n_out;
    longint sx, sy, sz;
    int cnt;
    centroid_t c;
    taken = new[cloud_pts.size()];
    n_out = 0;
    for (int i = 0; i < cloud_pts.size(); i++) begin
      if (taken[i]) continue;
      taken[i] = 1'b1;
      sx = cloud_pts[i].x; sy = cloud_pts[i].y; sz = cloud_pts[i].z;
      cnt = 1;
      for (int j = i + 1; j < cloud_pts.size(); j++) begin
        if (taken[j] || !near_seed(cloud_pts[i], cloud_pts[j])) continue;
        taken[j] = 1'b1;
        sx += cloud_pts[j].x; sy += cloud_pts[j].y; sz += cloud_pts[j].z;
        cnt++;
      end
      if (cnt < 2 || n_out >= 64) continue;
      // signed longint divide truncates toward zero
      c.cx = 32'(sx / cnt); c.cy = 32'(sy / cnt); c.cz = 32'(sz / cnt);
      c.members = 8'(cnt);
      c.last_res = 1'b0; c.empty_res = 1'b0; c.ovf = cloud_ovf;
      centroid_q.push_back(c);
      n_out++;
    end
    if (n_out == 0) begin
      c.cx = '0; c.cy = '0; c.cz = '0; c.members = '0;
      c.last_res = 1'b1; c.empty_res = 1'b1; c.ovf = cloud_ovf;
      centroid_q.push_back(c);
    end else begin
      centroid_q[centroid_q.size()-1].last_res = 1'b1;
    end
    cloud_pts.delete();
    cloud_ovf = 1'b0;
  endtask

  task automatic absorb_point(point_t p, bit last);
    if (cloud_pts.size() < StoreDepth) cloud_pts.push_back(p);
    else cloud_ovf = 1'b1;
    if (last) cluster_cloud();
  endtask

  // One point transaction, random gap first unless no_gap is set.
  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z, bit last,
                            bit no_gap = 0);
    int gap;
    point_t p;
    gap = no_gap ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = {z, y, x};
    in_tlast = last;
    do @(posedge clk); while (!in_tready);
    p.x = x; p.y = y; p.z = z;
    absorb_point(p, last);
    items_sent++;
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  // Drain, then let the block settle before the next step.
  task automatic wait_drained();
    while (centroid_q.size() != 0) @(posedge clk);
    repeat (IdleWait) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_radius(logic [30:0] r);
    wait_drained();
    cfg_we = 1'b1;
    cfg_wdata = {1'($urandom_range(0, 1)), r};  // bit 31 is unused
    radius_q = r;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Random cloud: points scattered around a few centers, some wide noise.
  task automatic send_random_cloud(int npts, logic [30:0] spread);
    logic [31:0] ctr[3][3];
    int k;
    for (int c = 0; c < 3; c++)
      for (int a = 0; a < 3; a++) ctr[c][a] = $urandom;
    for (int i = 0; i < npts; i++) begin
      k = $urandom_range(0, 2);
      if ($urandom_range(0, 7) == 0)
        send_point($urandom, $urandom, $urandom, i == npts - 1);
      else
        send_point(ctr[k][0] + 32'($urandom_range(0, spread)),
                   ctr[k][1] + 32'($urandom_range(0, spread)),
                   ctr[k][2] - 32'($urandom_range(0, spread)), i == npts - 1);
    end
  endtask

  task automatic test_directed();
    // close pair at default radius 1.0
    send_point(32'd0, 32'd0, 32'd0, 0);
    send_point(32'h8000, 32'd0, 32'd0, 1);
    // lone point gives the empty result
    send_point(32'h1234_5678, 32'h8765_4321, 32'h0, 1);
    // distance exactly at radius does not join
    send_point(32'd0, 32'd0, 32'd0, 0);
    send_point(32'h1_0000, 32'd0, 32'd0, 1);
    // coordinate extremes and negative truncation toward zero
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
    send_point(32'h7FFF_FFFE, 32'h7FFF_FFFE, 32'h7FFF_FFFE, 0);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
    send_point(32'h8000_0001, 32'h8000_0001, 32'h8000_0001, 0);
    send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    send_point(32'hFFFF_FFFE, 32'hFFFF_FFFE, 32'hFFFF_FFFE, 1);
    // zero radius: identical points still stay apart
    set_radius(31'd0);
    send_point(32'h10, 32'h10, 32'h10, 0);
    send_point(32'h10, 32'h10, 32'h10, 1);
    // widest radius: the negative extreme stays apart, the positive extreme takes the first mid point
    set_radius(31'h7FFF_FFFF);
    send_point(32'h8000_0000, 32'h0, 32'h0, 0);
    send_point(32'h7FFF_FFFF, 32'h0, 32'h0, 0);
    send_point(32'h3FFF_FFFF, 32'h0, 32'h0, 0);
    send_point(32'h0, 32'h3000_0000, 32'h0, 1);
  endtask

  // Full store: cluster of 128 plus dropped points, last one dropped too.
  task automatic test_overflow();
    set_radius(31'h1_0000);
    for (int i = 0; i < StoreDepth + 2; i++)
      send_point(32'(i), 32'h5, 32'hFFFF_FFF0, i == StoreDepth + 1, 1);
  endtask

  // Receiver holds off while the sender keeps offering, so input stalls.
  task automatic test_backpressure();
    set_radius(31'h4_0000);
    rx_hold = 1'b1;
    fork
      begin
        repeat (HoldCycles) @(posedge clk);
        rx_hold = 1'b0;
      end
    join_none
    for (int c = 0; c < 4; c++) send_random_cloud(12, 31'h1_0000);
  endtask

  task automatic test_random();
    logic [30:0] radii[4];
    logic [30:0] spreads[4];
    int quota;
    radii = '{31'h1_0000, 31'h20_0000, 31'h7FFF_FFFF, 31'($urandom)};
    spreads = '{31'h8000, 31'h10_0000, 31'h4000_0000, 31'hFFFF};
    for (int ph = 0; ph < 4; ph++) begin
      set_radius(radii[ph]);
      quota = items_sent + 40;
      while (items_sent < quota) begin
        // mostly short clouds; full-width noise from the outlier points
        send_random_cloud($urandom_range(1, 16), spreads[ph]);
        if ($urandom_range(0, 9) == 0) wait_drained();  // sender pause
      end
    end
  endtask

  // Receiver: random stall per result, plus hold requested by a test.
  always @(negedge clk) begin
    if (!rst_n || rx_hold) out_tready <= 1'b0;
    else if (rx_stall > 0) begin
      out_tready <= 1'b0;
      rx_stall <= rx_stall - 1;
    end else out_tready <= 1'b1;
  end

  // Result check against the oldest expected centroid.
  always @(posedge clk) begin
    centroid_t e;
    if (rst_n && out_tvalid && out_tready) begin
      rx_stall <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      if (centroid_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: %h", out_tdata);
      end else begin
        e = centroid_q.pop_front();
        if (out_tdata[31:0] !== e.cx || out_tdata[63:32] !== e.cy ||
            out_tdata[95:64] !== e.cz || out_tdata[103:96] !== e.members ||
            out_tlast !== e.last_res || out_tuser[0] !== e.empty_res ||
            out_tuser[1] !== e.ovf) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp c=%h,%h,%h m=%0d l=%b e=%b o=%b got c=%h,%h,%h m=%0d l=%b u=%b",
                     e.cx, e.cy, e.cz, e.members, e.last_res, e.empty_res, e.ovf,
                     out_tdata[31:0], out_tdata[63:32], out_tdata[95:64],
                     out_tdata[103:96], out_tlast, out_tuser);
        end
      end
    end
  end

  // Watchdog on cycles with no transaction on either stream.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WdogLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_overflow();
    test_backpressure();
    test_random();
    wait_drained();
    if (mismatches == 0 && centroid_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
